### rtl/core/sfrsc_pkg.sv
package sfrsc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 5;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam byte_t SYNC_A   = 8'h55;
  localparam byte_t SYNC_B   = 8'hAA;
  localparam byte_t SYNC_SUM = 8'hFF;

endpackage

### rtl/core/sync_frame_receiver_sum_check_unit.sv
// Fixed-length frame receiver: hunts for the sync pair 0x55 0xAA, collects FRAME_LEN bytes
// (sync included) into a single-port-read frame memory and checks that the last byte is the
// 8-bit wrapping sum of all the others. While hunting and collecting it takes one byte per
// cycle, unless the last byte of a sent frame still waits for the output register. A frame
// that passes is sent out one byte per cycle while the output takes them (position and end
// mark with each byte); input is held off until its last byte is in the output register.
// A frame that fails is rescanned from its third byte for a new sync pair, one memory read
// per byte, with input held off meanwhile. The sync pair itself is never stored, so there
// is no clearing pass after reset.
module sync_frame_receiver_sum_check_unit #(
  parameter int unsigned FRAME_LEN = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sfrsc_pkg::byte_t    rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sfrsc_pkg::byte_t    frame_byte_o,
  output sfrsc_pkg::pos_t     byte_position_o,
  output logic                last_byte_o
);

  localparam int unsigned AW = $clog2(FRAME_LEN);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  sfrsc_pkg::byte_t mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  sfrsc_pkg::byte_t mem_rdata;

  sfrsc_ctrl #(
    .FRAME_LEN (FRAME_LEN),
    .AW        (AW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_byte_o    (frame_byte_o),
    .byte_position_o (byte_position_o),
    .last_byte_o     (last_byte_o),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  sfrsc_mem #(
    .DEPTH (FRAME_LEN),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### rtl/core/sfrsc_mem.sv
module sfrsc_mem #(
  parameter int unsigned DEPTH = 20,
  parameter int unsigned AW    = 5
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  sfrsc_pkg::byte_t    wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output sfrsc_pkg::byte_t    rdata_o
);

  sfrsc_pkg::byte_t mem_q [DEPTH];
  sfrsc_pkg::byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sfrsc_ctrl.sv
module sfrsc_ctrl #(
  parameter int unsigned FRAME_LEN = 20,
  parameter int unsigned AW        = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sfrsc_pkg::byte_t    rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sfrsc_pkg::byte_t    frame_byte_o,
  output sfrsc_pkg::pos_t     byte_position_o,
  output logic                last_byte_o,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output sfrsc_pkg::byte_t    mem_wdata_o,
  output logic                mem_re_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  sfrsc_pkg::byte_t    mem_rdata_i
);

  localparam logic [AW-1:0] LAST  = AW'(FRAME_LEN - 1);
  localparam logic [AW-1:0] FIRST = AW'(2);
  localparam int unsigned   PW    = (AW > sfrsc_pkg::POS_W) ? AW : sfrsc_pkg::POS_W;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_SYNC,
    ST_FILL,
    ST_CHECK,
    ST_RESCAN,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SC_HUNT,
    SC_SYNC,
    SC_FILL
  } scan_e;

  state_e           st_q, st_d;
  scan_e            scan_q, scan_d;
  logic [AW-1:0]    wp_q, wp_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    pidx_q, pidx_d;
  logic             pend_q, pend_d;
  sfrsc_pkg::byte_t sum_q, sum_d;
  logic             ovld_q, ovld_d;
  sfrsc_pkg::byte_t obyte_q, obyte_d;
  logic [AW-1:0]    opos_q, opos_d;

  sfrsc_pkg::byte_t stage_byte;
  sfrsc_pkg::byte_t rbyte;
  logic             in_acc;
  logic             move;
  logic             issue;
  logic [PW-1:0]    pos_ext;

  assign in_ready_o = (st_q inside {ST_HUNT, ST_SYNC, ST_FILL, ST_CHECK}) && !pend_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign move       = pend_q && (!ovld_q || out_ready_i);
  assign rbyte      = mem_rdata_i;

  // sync pair is never stored, it is put back on the way out
  always_comb begin
    if (pidx_q == AW'(0)) begin
      stage_byte = sfrsc_pkg::SYNC_A;
    end else if (pidx_q == AW'(1)) begin
      stage_byte = sfrsc_pkg::SYNC_B;
    end else begin
      stage_byte = mem_rdata_i;
    end
  end

  always_comb begin
    st_d        = st_q;
    scan_d      = scan_q;
    wp_d        = wp_q;
    idx_d       = idx_q;
    pidx_d      = pidx_q;
    sum_d       = sum_q;
    issue       = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = wp_q;
    mem_wdata_o = rx_byte_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q;

    case (st_q)
      ST_HUNT: begin
        if (in_acc && rx_byte_i == sfrsc_pkg::SYNC_A) begin
          st_d = ST_SYNC;
        end
      end
      ST_SYNC: begin
        if (in_acc) begin
          if (rx_byte_i == sfrsc_pkg::SYNC_B) begin
            wp_d  = FIRST;
            sum_d = sfrsc_pkg::SYNC_SUM;
            st_d  = ST_FILL;
          end else begin
            st_d = ST_HUNT;
          end
        end
      end
      ST_FILL: begin
        if (in_acc) begin
          mem_we_o = 1'b1;
          sum_d    = sum_q + rx_byte_i;
          wp_d     = wp_q + AW'(1);
          if (wp_d == LAST) begin
            st_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (in_acc) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = LAST;
          if (sum_q == rx_byte_i) begin
            idx_d = '0;
            st_d  = ST_EMIT;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = FIRST;
            idx_d       = FIRST;
            scan_d      = SC_HUNT;
            st_d        = ST_RESCAN;
          end
        end
      end
      ST_RESCAN: begin
        case (scan_q)
          SC_HUNT: begin
            if (rbyte == sfrsc_pkg::SYNC_A) begin
              scan_d = SC_SYNC;
            end
          end
          SC_SYNC: begin
            if (rbyte == sfrsc_pkg::SYNC_B) begin
              scan_d = SC_FILL;
              wp_d   = FIRST;
              sum_d  = sfrsc_pkg::SYNC_SUM;
            end else begin
              scan_d = SC_HUNT;
            end
          end
          SC_FILL: begin
            mem_we_o    = 1'b1;
            mem_wdata_o = rbyte;
            sum_d       = sum_q + rbyte;
            wp_d        = wp_q + AW'(1);
          end
          default: begin
            scan_d = SC_HUNT;
          end
        endcase
        if (idx_q == LAST) begin
          case (scan_d)
            SC_SYNC: st_d = ST_SYNC;
            SC_FILL: st_d = (wp_d == LAST) ? ST_CHECK : ST_FILL;
            default: st_d = ST_HUNT;
          endcase
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + AW'(1);
          idx_d       = idx_q + AW'(1);
        end
      end
      ST_EMIT: begin
        issue = !pend_q || move;
        if (issue) begin
          mem_re_o    = (idx_q >= FIRST);
          mem_raddr_o = idx_q;
          pidx_d      = idx_q;
          idx_d       = idx_q + AW'(1);
          if (idx_q == LAST) begin
            st_d = ST_HUNT;
          end
        end
      end
      default: begin
        st_d = ST_HUNT;
      end
    endcase
  end

  always_comb begin
    pend_d  = pend_q;
    ovld_d  = ovld_q;
    obyte_d = obyte_q;
    opos_d  = opos_q;
    if (move) begin
      ovld_d  = 1'b1;
      obyte_d = stage_byte;
      opos_d  = pidx_q;
      pend_d  = 1'b0;
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end
    if (issue) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_HUNT;
      scan_q  <= SC_HUNT;
      wp_q    <= '0;
      idx_q   <= '0;
      pidx_q  <= '0;
      pend_q  <= 1'b0;
      sum_q   <= '0;
      ovld_q  <= 1'b0;
      obyte_q <= '0;
      opos_q  <= '0;
    end else begin
      st_q    <= st_d;
      scan_q  <= scan_d;
      wp_q    <= wp_d;
      idx_q   <= idx_d;
      pidx_q  <= pidx_d;
      pend_q  <= pend_d;
      sum_q   <= sum_d;
      ovld_q  <= ovld_d;
      obyte_q <= obyte_d;
      opos_q  <= opos_d;
    end
  end

  assign pos_ext         = PW'(opos_q);
  assign out_valid_o     = ovld_q;
  assign frame_byte_o    = obyte_q;
  assign byte_position_o = pos_ext[sfrsc_pkg::POS_W-1:0];
  assign last_byte_o     = (opos_q == LAST);

endmodule
